/* rtl/core/bfc_pkg.sv */
package bfc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int IN_WIDTH        = 32;

    localparam logic [1:0] FUNC_LOAD_WORLD = 2'd0;
    localparam logic [1:0] FUNC_LOAD_VP    = 2'd1;
    localparam logic [1:0] FUNC_TEST       = 2'd2;
    localparam logic [1:0] FUNC_RESERVED   = 2'd3;

    typedef struct packed {
        logic clear;
        logic phase_corner;
        logic [3:0] step;
    } bfc_cmd_t;

endpackage

/* rtl/core/bfc_datapath.sv */
module bfc_datapath
    import bfc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load_en,
    input  logic                          load_sel,
    input  logic [1:0]                    load_row,
    input  logic signed [4*IN_WIDTH-1:0]  load_data,
    input  logic                          box_en,
    input  logic signed [6*IN_WIDTH-1:0]  box_data,
    input  bfc_cmd_t                      cmd,
    output logic                          visible
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW + 3;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE  = CW'(1) << FRAC_BITS;

    logic signed [CW-1:0] wm_reg [16];
    logic signed [CW-1:0] vp_reg [16];
    logic signed [CW-1:0] wvp_reg [16];
    logic signed [CW-1:0] lo_reg [3];
    logic signed [CW-1:0] hi_reg [3];
    logic [5:0] cull_reg;
    logic [5:0] cull_next;
    logic signed [CW-1:0] a_vec [4];
    logic signed [CW-1:0] b_mat [16];
    logic signed [CW-1:0] res [4];

    function automatic logic signed [CW-1:0] sat_in(input logic signed [IN_WIDTH-1:0] v);
        logic signed [IN_WIDTH+CW-1:0] e;
        begin
            e = (IN_WIDTH+CW)'(v);
            if (e > (IN_WIDTH+CW)'(CMAX))
            begin
                sat_in = CMAX;
            end
            else if (e < (IN_WIDTH+CW)'(CMIN))
            begin
                sat_in = CMIN;
            end
            else
            begin
                sat_in = e[CW-1:0];
            end
        end
    endfunction

    function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b, input logic sub);
        logic signed [CW:0] s;
        begin
            s = sub ? ((CW+1)'(a) - (CW+1)'(b)) : ((CW+1)'(a) + (CW+1)'(b));
            if (s > (CW+1)'(CMAX))
            begin
                sat_add = CMAX;
            end
            else if (s < (CW+1)'(CMIN))
            begin
                sat_add = CMIN;
            end
            else
            begin
                sat_add = s[CW-1:0];
            end
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (load_sel)
                begin
                    vp_reg[{load_row, 2'(j)}] <= sat_in(load_data[j*IN_WIDTH +: IN_WIDTH]);
                end
                else
                begin
                    wm_reg[{load_row, 2'(j)}] <= sat_in(load_data[j*IN_WIDTH +: IN_WIDTH]);
                end
            end
        end
        if (box_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k] <= sat_add(sat_in(box_data[k*IN_WIDTH +: IN_WIDTH]),
                                     sat_in(box_data[(k+3)*IN_WIDTH +: IN_WIDTH]), 1'b1);
                hi_reg[k] <= sat_add(sat_in(box_data[k*IN_WIDTH +: IN_WIDTH]),
                                     sat_in(box_data[(k+3)*IN_WIDTH +: IN_WIDTH]), 1'b0);
            end
        end
    end

    // Steps 0..3 form one row of world * view_proj each; steps 0..7 of the corner
    // phase project one corner each on the same 16-multiplier array.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            b_mat[i] = cmd.phase_corner ? wvp_reg[i] : vp_reg[i];
        end
        if (cmd.phase_corner)
        begin
            a_vec[0] = cmd.step[0] ? lo_reg[0] : hi_reg[0];
            a_vec[1] = cmd.step[1] ? lo_reg[1] : hi_reg[1];
            a_vec[2] = cmd.step[2] ? lo_reg[2] : hi_reg[2];
            a_vec[3] = ONE;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                a_vec[k] = wm_reg[{cmd.step[1:0], 2'(k)}];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_col
            logic signed [2*CW-1:0] p [4];
            logic signed [PW-1:0] acc;
            logic signed [PW-1:0] sh;
            for (genvar k = 0; k < 4; k++)
            begin : g_mul
                always_ff @(posedge clk)
                begin
                    p[k] <= a_vec[k] * b_mat[k*4+g];
                end
            end
            always_comb
            begin
                acc = PW'(p[0]) + PW'(p[1]) + PW'(p[2]) + PW'(p[3]);
                sh = acc >>> FRAC_BITS;
                if (sh > PW'(CMAX))
                begin
                    res[g] = CMAX;
                end
                else if (sh < PW'(CMIN))
                begin
                    res[g] = CMIN;
                end
                else
                begin
                    res[g] = sh[CW-1:0];
                end
            end
        end
    endgenerate

    // The products of command step n are summed while the command of step n+1 stands.
    bfc_cmd_t cmd_d_reg;
    logic     cmd_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_v_reg <= 1'b0;
            cmd_d_reg <= '0;
        end
        else
        begin
            cmd_v_reg <= cmd.step != 4'hF;
            cmd_d_reg <= cmd;
        end
    end

    always_comb
    begin
        cull_next = cull_reg;
        if (cmd_v_reg && cmd_d_reg.phase_corner)
        begin
            cull_next[0] = cull_reg[0] & ((CW+1)'(res[0]) < -(CW+1)'(res[3]));
            cull_next[1] = cull_reg[1] & ((CW+1)'(res[1]) < -(CW+1)'(res[3]));
            cull_next[2] = cull_reg[2] & (res[2] < 0);
            cull_next[3] = cull_reg[3] & (res[0] > res[3]);
            cull_next[4] = cull_reg[4] & (res[1] > res[3]);
            cull_next[5] = cull_reg[5] & (res[2] > res[3]);
        end
        if (cmd.clear)
        begin
            cull_next = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        cull_reg <= cull_next;
        if (cmd_v_reg && !cmd_d_reg.phase_corner)
        begin
            for (int j = 0; j < 4; j++)
            begin
                wvp_reg[{cmd_d_reg.step[1:0], 2'(j)}] <= res[j];
            end
        end
    end

    assign visible = ~|cull_next;

endmodule

/* rtl/core/bfc_ctrl.sv */
module bfc_ctrl
    import bfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     stall,
    output logic     busy,
    output bfc_cmd_t cmd,
    output logic     done
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MAT    = 2'd1;
    localparam logic [1:0] ST_CORNER = 2'd2;
    localparam logic [1:0] ST_DRAIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 4'd1;
        cmd.clear  = 1'b0;
        cmd.phase_corner = 1'b0;
        cmd.step   = cnt_reg;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.step = 4'hF;
                cnt_next = '0;
                if (start)
                begin
                    state_next = ST_MAT;
                    cmd.clear  = 1'b1;
                end
            end
            ST_MAT:
            begin
                // The last product row is written in the cycle after its step.
                if (cnt_reg == 4'd4)
                begin
                    cmd.step   = 4'hF;
                    state_next = ST_CORNER;
                    cnt_next   = '0;
                end
            end
            ST_CORNER:
            begin
                cmd.phase_corner = 1'b1;
                if (cnt_reg == 4'd7)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.phase_corner = 1'b1;
                cmd.step = 4'hF;
                if (!stall)
                begin
                    done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;

    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_DRAIN)
        else $error("done outside drain state");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> state_reg == ST_MAT)
        else $error("start not taken");
    a_mat_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORNER && $past(state_reg) == ST_MAT) |-> $past(cnt_reg) == 4'd4)
        else $error("matrix phase length");
    a_stall_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !done)
        else $error("done while result register is held");

endmodule

/* rtl/core/box_frustum_cull_unit.sv */
// Load words give no result; they are taken back to back while idle.
// A test word gives one result word: the matrix product is formed row by row, its last
// row settles, the 8 box corners are projected on one 16-multiplier array, and the
// final products drain into the result register; no new word is taken before that.
// A result that waits on the receiver holds the controller and stalls the input.
// Reset clears control state only; matrices are undefined until loaded.
module box_frustum_cull_unit
    import bfc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [3:0]   s_tuser,  // func[1:0], row[3:2]
    input  logic [319:0] s_tdata,  // m0, m1, m2, m3, center_x/y/z, extent_x/y/z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata   // visible[0], zero fill
);

    logic     busy;
    logic     done;
    logic     vis;
    bfc_cmd_t cmd;
    logic     out_v_reg;
    logic     out_d_reg;
    logic     acc;
    logic     start;

    assign s_tready = !busy;
    assign acc      = s_tvalid && s_tready;
    assign start    = acc && s_tuser[1:0] == FUNC_TEST;

    bfc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stall (out_v_reg && !m_tready),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done)
    );

    bfc_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (acc && (s_tuser[1:0] == FUNC_LOAD_WORLD || s_tuser[1:0] == FUNC_LOAD_VP)),
        .load_sel  (s_tuser[1:0] == FUNC_LOAD_VP),
        .load_row  (s_tuser[3:2]),
        .load_data (s_tdata[127:0]),
        .box_en    (start),
        .box_data  (s_tdata[319:128]),
        .cmd       (cmd),
        .visible   (vis)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (done)
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_d_reg <= vis;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_d_reg};

endmodule
